[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks on aclk, quiet while aresetn is low.

// Property that holds at every edge.
`define WWPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define WWPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/wwpc_pkg.sv]
`timescale 1ns / 1ps

package wwpc_pkg;

    localparam int PATTERN_REG_BYTES = 32;
    localparam int PAT_IDX_W         = $clog2(PATTERN_REG_BYTES);
    localparam int CFG_DATA_W        = 64;
    localparam int LEN_W             = 6;
    localparam int COUNT_W           = 17;
    localparam int SEL_W             = 24;
    localparam int WORD_W            = 40;
    localparam int OUT_INDEX_W       = 24;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] cfg_addr_t;

    // register map
    localparam cfg_addr_t CFG_PATTERN_0   = 3'd0;
    localparam cfg_addr_t CFG_PATTERN_1   = 3'd1;
    localparam cfg_addr_t CFG_PATTERN_2   = 3'd2;
    localparam cfg_addr_t CFG_PATTERN_3   = 3'd3;
    localparam cfg_addr_t CFG_PATTERN_LEN = 3'd4;
    localparam cfg_addr_t CFG_WHOLE_WORDS = 3'd5;
    localparam cfg_addr_t CFG_MIN_MATCHES = 3'd6;

    localparam byte_t CHAR_0          = 8'h30;
    localparam byte_t CHAR_9          = 8'h39;
    localparam byte_t CHAR_UPPER_A    = 8'h41;
    localparam byte_t CHAR_UPPER_Z    = 8'h5A;
    localparam byte_t CHAR_LOWER_A    = 8'h61;
    localparam byte_t CHAR_LOWER_Z    = 8'h7A;
    localparam byte_t CHAR_UNDERSCORE = 8'h5F;
    localparam byte_t CHAR_NUL        = 8'h00;

    // ASCII letter, digit or underscore
    function automatic logic is_word_byte(byte_t c);
        return (c >= CHAR_0 && c <= CHAR_9) ||
               (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
               (c == CHAR_UNDERSCORE);
    endfunction

endpackage

[design/whole_word_pattern_counter.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Ports                                   Direction  Moves
// --------  --------------------------------------  ---------  ---------------------------
// cfg       cfg_we, cfg_index, cfg_data             in         register write, no wait
// s_        s_valid/s_ready, s_text_byte, s_last..  in         one text byte per transfer
// m_        m_valid/m_ready, m_article_index, ...   out        one report per article end
//
// One byte per cycle sustained while no last byte waits on a stalled m_ side: a byte
// sits in the input register while the window compare and counter update run, and its
// report lands in the output register; a last byte waits in the input register for room.
// Synchronous active-low reset clears the control state and loads register defaults
// (pattern length 1, minimum 1); the text window is payload and is not cleared.
// A stalled m_ side stalls input only while a last byte waits; other bytes keep flowing.
module whole_word_pattern_counter #(
    parameter int MAX_PATTERN_BYTES  = 32,
    parameter int MAX_ARTICLE_BYTES  = 65536,
    parameter int ARTICLE_INDEX_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_we,
    input  wwpc_pkg::cfg_addr_t                  cfg_index,
    input  logic [wwpc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // text stream
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_text_byte,
    input  logic                                 s_last_byte,
    // article reports
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [wwpc_pkg::OUT_INDEX_W-1:0]     m_article_index,
    output logic [wwpc_pkg::COUNT_W-1:0]         m_match_count,
    output logic                                 m_article_selected,
    output logic [wwpc_pkg::SEL_W-1:0]           m_selected_total,
    output logic [wwpc_pkg::WORD_W-1:0]          m_word_match_total,
    output logic                                 m_new_maximum,
    output logic [wwpc_pkg::COUNT_W-1:0]         m_maximum_count,
    output logic [wwpc_pkg::OUT_INDEX_W-1:0]     m_maximum_article_index
);
    import wwpc_pkg::*;

    // Only this many trailing bytes can take part in a match; one more holds the
    // byte in front of the longest match for the word-boundary test.
    localparam int CMP_BYTES   = (MAX_PATTERN_BYTES < PATTERN_REG_BYTES) ?
                                 MAX_PATTERN_BYTES : PATTERN_REG_BYTES;
    localparam int WIN_DEPTH   = CMP_BYTES + 1;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int SEEN_W      = $clog2(WIN_DEPTH + 1);
    localparam int MATCH_CAP_I = (MAX_ARTICLE_BYTES < 131071) ? MAX_ARTICLE_BYTES : 131071;

    localparam logic [COUNT_W-1:0]            MATCH_CAP = COUNT_W'(MATCH_CAP_I);
    localparam logic [ARTICLE_INDEX_BITS-1:0] INDEX_CAP = '1;
    localparam logic [SEL_W-1:0]              SEL_CAP   = '1;
    localparam logic [WORD_W-1:0]             WORD_CAP  = '1;
    localparam logic [SEEN_W-1:0]             SEEN_MAX  = SEEN_W'(WIN_DEPTH);

    // ---------------------------------------------------------------- registers
    logic [PATTERN_REG_BYTES*8-1:0] pattern_reg;
    logic [LEN_W-1:0]               length_reg;
    logic                           whole_reg;
    logic [COUNT_W-1:0]             min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
            whole_reg   <= 1'b0;
            min_reg     <= COUNT_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PATTERN_0:   pattern_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_PATTERN_1:   pattern_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_PATTERN_2:   pattern_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_PATTERN_3:   pattern_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                CFG_PATTERN_LEN: length_reg <= cfg_data[LEN_W-1:0];
                CFG_WHOLE_WORDS: whole_reg  <= cfg_data[0];
                CFG_MIN_MATCHES: min_reg    <= cfg_data[COUNT_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // Effective length, clamped to the compare span.
    logic [LEN_W-1:0] eff_len;
    assign eff_len = (length_reg > LEN_W'(CMP_BYTES)) ? LEN_W'(CMP_BYTES) : length_reg;

    // Pattern laid out against the window: window[k] (newest first) must equal
    // pattern byte len-1-k. Depends on configuration only.
    byte_t                aligned [CMP_BYTES];
    logic [CMP_BYTES-1:0] use_pos;

    always_comb begin
        logic [LEN_W-1:0] pidx;
        for (int k = 0; k < CMP_BYTES; k++) begin
            pidx       = eff_len - LEN_W'(k) - LEN_W'(1);
            aligned[k] = pattern_reg[pidx[PAT_IDX_W-1:0]*8 +: 8];
            use_pos[k] = LEN_W'(k) < eff_len;
        end
    end

    // ---------------------------------------------------------------- input stage
    logic  in_valid_reg;
    byte_t in_byte_reg;
    logic  in_last_reg;
    logic  advance;
    logic  out_free;

    assign out_free = !m_valid || m_ready;
    // a last byte needs room in the report register, other bytes never wait
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_text_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // ---------------------------------------------------------------- article state
    byte_t                         win_reg [WIN_DEPTH];
    byte_t                         win_next [WIN_DEPTH];
    logic [SEEN_W-1:0]             seen_reg;
    logic [SEEN_W-1:0]             seen_next;
    logic                          ended_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic [ARTICLE_INDEX_BITS-1:0] article_reg;
    logic [SEL_W-1:0]              sel_reg;
    logic [WORD_W-1:0]             word_reg;
    logic [COUNT_W-1:0]            best_count_reg;
    logic [ARTICLE_INDEX_BITS-1:0] best_article_reg;

    logic                   byte_is_nul;
    logic                   take_byte;
    logic [WIN_IDX_W-1:0]   len_idx;
    logic [SEEN_W-1:0]      len_seen;
    logic                   cur_eq, new_eq;
    logic                   cur_full, new_full;
    logic                   cur_before_ok, new_before_ok;
    logic                   hit_before_push, hit_after_push;
    logic [COUNT_W:0]       count_sum;
    logic [COUNT_W-1:0]     count_final;
    logic                   selected;
    logic                   new_max;
    logic [SEL_W-1:0]       sel_next;
    logic [WORD_W:0]        word_sum;
    logic [WORD_W-1:0]      word_next;

    assign byte_is_nul = (in_byte_reg == CHAR_NUL);
    assign take_byte   = !ended_reg && !byte_is_nul;
    assign len_idx     = eff_len[WIN_IDX_W-1:0];
    assign len_seen    = SEEN_W'(eff_len);
    assign seen_next   = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + SEEN_W'(1);

    always_comb begin
        win_next[0] = in_byte_reg;
        for (int i = 1; i < WIN_DEPTH; i++) begin
            win_next[i] = win_reg[i-1];
        end
    end

    // Two compares: the window as it stands (match closed by this byte as the
    // following byte) and the window after this byte is shifted in.
    always_comb begin
        cur_eq = 1'b1;
        new_eq = 1'b1;
        for (int k = 0; k < CMP_BYTES; k++) begin
            if (use_pos[k]) begin
                cur_eq = cur_eq && (win_reg[k] == aligned[k]);
                new_eq = new_eq && (win_next[k] == aligned[k]);
            end
        end
    end

    assign cur_full = (eff_len != '0) && (seen_reg >= len_seen) && cur_eq;
    assign new_full = (eff_len != '0) && (seen_next >= len_seen) && new_eq;

    // byte in front of the match: absent at article start, else must be non-word
    assign cur_before_ok = !((seen_reg > len_seen) && is_word_byte(win_reg[len_idx]));
    assign new_before_ok = !((seen_next > len_seen) && is_word_byte(win_next[len_idx]));

    // Whole words: a pending match closes on a non-word byte or on a NUL.
    assign hit_before_push = !ended_reg && whole_reg && cur_full && cur_before_ok &&
                             (byte_is_nul || !is_word_byte(in_byte_reg));
    // Plain mode counts on arrival; whole words only when the article edge follows.
    assign hit_after_push  = take_byte && new_full &&
                             (!whole_reg || (in_last_reg && new_before_ok));

    assign count_sum   = {1'b0, count_reg} + (COUNT_W+1)'(hit_before_push)
                                           + (COUNT_W+1)'(hit_after_push);
    assign count_final = (count_sum > {1'b0, MATCH_CAP}) ? MATCH_CAP : count_sum[COUNT_W-1:0];

    assign selected  = count_final >= min_reg;
    assign sel_next  = (selected && sel_reg != SEL_CAP) ? sel_reg + SEL_W'(1) : sel_reg;
    assign word_sum  = {1'b0, word_reg} + (WORD_W+1)'(count_final);
    assign word_next = (word_sum > {1'b0, WORD_CAP}) ? WORD_CAP : word_sum[WORD_W-1:0];
    assign new_max   = count_final >= best_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg         <= '0;
            ended_reg        <= 1'b0;
            count_reg        <= '0;
            article_reg      <= '0;
            sel_reg          <= '0;
            word_reg         <= '0;
            best_count_reg   <= '0;
            best_article_reg <= '0;
        end else if (advance) begin
            if (in_last_reg) begin
                seen_reg  <= '0;
                ended_reg <= 1'b0;
                count_reg <= '0;
                if (article_reg != INDEX_CAP) begin
                    article_reg <= article_reg + ARTICLE_INDEX_BITS'(1);
                end
                sel_reg  <= sel_next;
                word_reg <= word_next;
                if (new_max) begin
                    best_count_reg   <= count_final;
                    best_article_reg <= article_reg;
                end
            end else begin
                if (take_byte) begin
                    seen_reg <= seen_next;
                end
                ended_reg <= ended_reg || byte_is_nul;
                count_reg <= count_final;
            end
        end
    end

    // window contents only matter below seen_reg, so no reset
    always_ff @(posedge aclk) begin
        if (advance && take_byte) begin
            win_reg <= win_next;
        end
    end

    // ---------------------------------------------------------------- report register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_article_index         <= OUT_INDEX_W'(article_reg);
            m_match_count           <= count_final;
            m_article_selected      <= selected;
            m_selected_total        <= sel_next;
            m_word_match_total      <= word_next;
            m_new_maximum           <= new_max;
            m_maximum_count         <= new_max ? count_final : best_count_reg;
            m_maximum_article_index <= OUT_INDEX_W'(new_max ? article_reg : best_article_reg);
        end
    end

    assign m_valid = m_valid_reg;

    // ---------------------------------------------------------------- checks
    `WWPC_ASSERT(a_count_capped, count_reg <= MATCH_CAP, "article count above its cap")
    `WWPC_ASSERT_NEXT(a_report_loaded, advance && in_last_reg, m_valid_reg,
        "article end did not load a report")
    `WWPC_ASSERT_NEXT(a_article_cleared, advance && in_last_reg,
        count_reg == '0 && seen_reg == '0 && !ended_reg,
        "article state not cleared after report")
    `WWPC_ASSERT(a_max_covers_count, !m_valid_reg || (m_maximum_count >= m_match_count),
        "reported maximum below reported count")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// Word-pattern counter check: a directed table first, then random pattern phases.
// Every accepted text byte feeds a local model of the counter. Each article report of
// the model, or of a typed row, is queued; the m_ side checks them in order, field by field.
module testbench;
    import wwpc_pkg::*;

    localparam int WIN_DEPTH    = 34;      // longest pattern plus a byte on each side
    localparam int MATCH_LIMIT  = 65536;   // per-article count saturates here
    localparam int IDLE_LIMIT   = 1000;    // cycles without any transfer before giving up
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASE_ITEMS  = 200;
    localparam int QUIET_TAIL   = 250;     // final stretch runs with no random gaps or receiver stalls
    localparam int REPORT_LIMIT = 10;

    localparam byte_t CHAR_LOWER_B = 8'h62;
    localparam byte_t CHAR_SPACE   = 8'h20;
    localparam byte_t CHAR_HIGH    = 8'hFF;

    // Word bytes at the edges of their ranges plus 'b', and the non-word bytes next to them plus 0xFF.
    localparam byte_t WORD_PICKS [8] = '{CHAR_0, CHAR_9, CHAR_UPPER_A, CHAR_UPPER_Z,
                                         CHAR_LOWER_A, CHAR_LOWER_Z, CHAR_UNDERSCORE,
                                         CHAR_LOWER_B};
    localparam byte_t EDGE_PICKS [8] = '{CHAR_0 - 8'd1, CHAR_9 + 8'd1, CHAR_UPPER_A - 8'd1,
                                         CHAR_UPPER_Z + 8'd1, CHAR_LOWER_A - 8'd1,
                                         CHAR_LOWER_Z + 8'd1, CHAR_UNDERSCORE - 8'd1,
                                         CHAR_HIGH};

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] article_index;
        logic [COUNT_W-1:0]     match_count;
        logic                   article_selected;
        logic [SEL_W-1:0]       selected_total;
        logic [WORD_W-1:0]      word_match_total;
        logic                   new_maximum;
        logic [COUNT_W-1:0]     maximum_count;
        logic [OUT_INDEX_W-1:0] maximum_article_index;
    } article_report_t;

    typedef enum logic {ROW_REG, ROW_TEXT} row_kind_t;

    typedef struct {
        row_kind_t       kind;
        cfg_addr_t       addr;
        logic [63:0]     data;
        byte_t           text;
        logic            last;
        logic            typed;    // report below is the expectation, not the model's
        article_report_t report;
    } stim_row_t;

    // ---------------------------------------------------------------- DUT hookup
    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_we      = 1'b0;
    cfg_addr_t              cfg_index   = CFG_PATTERN_0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    byte_t                  s_text_byte = '0;
    logic                   s_last_byte = 1'b0;
    logic                   m_valid;
    logic                   m_ready     = 1'b1;
    logic [OUT_INDEX_W-1:0] m_article_index;
    logic [COUNT_W-1:0]     m_match_count;
    logic                   m_article_selected;
    logic [SEL_W-1:0]       m_selected_total;
    logic [WORD_W-1:0]      m_word_match_total;
    logic                   m_new_maximum;
    logic [COUNT_W-1:0]     m_maximum_count;
    logic [OUT_INDEX_W-1:0] m_maximum_article_index;

    whole_word_pattern_counter u_top (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_text_byte             (s_text_byte),
        .s_last_byte             (s_last_byte),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_article_index         (m_article_index),
        .m_match_count           (m_match_count),
        .m_article_selected      (m_article_selected),
        .m_selected_total        (m_selected_total),
        .m_word_match_total      (m_word_match_total),
        .m_new_maximum           (m_new_maximum),
        .m_maximum_count         (m_maximum_count),
        .m_maximum_article_index (m_maximum_article_index)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- counter model
    // register copies
    logic [63:0]        pat_word [4];
    logic [LEN_W-1:0]   pat_len_reg;
    logic               whole_mode;
    logic [COUNT_W-1:0] min_count;

    // article state; win_bytes[0] is the newest text byte
    byte_t                  win_bytes [WIN_DEPTH];
    int                     win_fill;
    logic                   text_done;
    logic [COUNT_W-1:0]     cur_matches;
    // stream totals
    logic [OUT_INDEX_W-1:0] articles_done;
    logic [SEL_W-1:0]       selected_sum;
    logic [WORD_W-1:0]      match_sum;
    logic [COUNT_W-1:0]     peak_count;
    logic [OUT_INDEX_W-1:0] peak_article;

    article_report_t expected_reports [$];
    article_report_t seen_report;
    article_report_t head_report;
    stim_row_t       directed_rows [$];

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  idle_cycles    = 0;
    int  stall_left     = 0;
    bit  quiet_tail     = 1'b0;

    assign seen_report = {m_article_index, m_match_count, m_article_selected,
                          m_selected_total, m_word_match_total, m_new_maximum,
                          m_maximum_count, m_maximum_article_index};

    // lengths past 32 clamp to 32
    function automatic int eff_len();
        return (pat_len_reg > 6'd32) ? 32 : int'(pat_len_reg);
    endfunction

    function automatic bit is_text_char(byte_t c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
    endfunction

    // pattern ends at the newest window byte?
    function automatic bit pattern_ends_here(int len);
        if (len == 0 || win_fill < len) return 1'b0;
        for (int k = 0; k < len; k++) begin
            if (pat_word[k / 8][(k % 8) * 8 +: 8] != win_bytes[len - 1 - k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void bump_matches();
        if (cur_matches < MATCH_LIMIT) cur_matches++;
    endfunction

    // whole-word rule: nothing word-like right before or right after the match
    function automatic void whole_word_check(logic after_edge, byte_t after);
        int len;
        len = eff_len();
        if (!pattern_ends_here(len)) return;
        if (win_fill > len && is_text_char(win_bytes[len])) return;
        if (!after_edge && is_text_char(after)) return;
        bump_matches();
    endfunction

    function automatic void clear_article();
        foreach (win_bytes[i]) win_bytes[i] = '0;
        win_fill    = 0;
        text_done   = 1'b0;
        cur_matches = '0;
    endfunction

    function automatic void apply_reg(cfg_addr_t addr, logic [63:0] data);
        case (addr)
            CFG_PATTERN_0, CFG_PATTERN_1, CFG_PATTERN_2, CFG_PATTERN_3: begin
                pat_word[addr[1:0]] = data;
            end
            CFG_PATTERN_LEN: pat_len_reg = data[LEN_W-1:0];
            CFG_WHOLE_WORDS: whole_mode  = data[0];
            CFG_MIN_MATCHES: min_count   = data[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the model by one text byte; returns 1 with the article report on a last byte.
    function automatic bit predict_text_byte(byte_t b, logic last, output article_report_t rep);
        logic [WORD_W:0] sum;
        logic            sel;
        logic            peak;
        rep = '0;
        if (!text_done) begin
            if (b == CHAR_NUL) begin
                // NUL closes the text, so it acts as the trailing edge
                if (whole_mode) whole_word_check(1'b1, CHAR_NUL);
                text_done = 1'b1;
            end else begin
                if (whole_mode) whole_word_check(1'b0, b);
                for (int i = WIN_DEPTH - 1; i > 0; i--) win_bytes[i] = win_bytes[i - 1];
                win_bytes[0] = b;
                if (win_fill < WIN_DEPTH) win_fill++;
                if (!whole_mode && pattern_ends_here(eff_len())) bump_matches();
            end
        end
        if (!last) return 1'b0;
        // article end is a boundary too
        if (!text_done && whole_mode) whole_word_check(1'b1, CHAR_NUL);

        sel = (cur_matches >= min_count);
        if (sel && selected_sum != '1) selected_sum++;
        sum       = {1'b0, match_sum} + cur_matches;
        match_sum = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
        peak      = (cur_matches >= peak_count);   // later ties take over
        if (peak) begin
            peak_count   = cur_matches;
            peak_article = articles_done;
        end

        rep.article_index         = articles_done;
        rep.match_count           = cur_matches;
        rep.article_selected      = sel;
        rep.selected_total        = selected_sum;
        rep.word_match_total      = match_sum;
        rep.new_maximum           = peak;
        rep.maximum_count         = peak_count;
        rep.maximum_article_index = peak_article;

        if (articles_done != '1) articles_done++;
        clear_article();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- directed table rows
    function automatic stim_row_t typed_row(byte_t b, logic last, article_report_t rep);
        stim_row_t row;
        row.kind   = ROW_TEXT;
        row.addr   = CFG_PATTERN_0;
        row.data   = '0;
        row.text   = b;
        row.last   = last;
        row.typed  = 1'b1;
        row.report = rep;
        return row;
    endfunction

    function automatic stim_row_t text_row(byte_t b, logic last);
        stim_row_t row;
        row       = typed_row(b, last, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic stim_row_t reg_row(cfg_addr_t addr, logic [63:0] data);
        stim_row_t row;
        row      = text_row(CHAR_NUL, 1'b0);
        row.kind = ROW_REG;
        row.addr = addr;
        row.data = data;
        return row;
    endfunction

    // append one row to the directed table
    function automatic void add_row(stim_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    // Occasionally set don't-care bits above the register field.
    function automatic logic [63:0] with_noise(logic [63:0] value, logic [63:0] field_mask);
        logic [63:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
        return (junk & ~field_mask) | (value & field_mask);
    endfunction

    // ---------------------------------------------------------------- drivers
    // One register write, then cfg_we is cleared again, so it never gets two updates in one step.
    task automatic write_reg(cfg_addr_t addr, logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        apply_reg(addr, data);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold off the sender until every queued report has come back, then let the pipeline settle.
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_text(byte_t b, logic last, logic typed, article_report_t typed_rep);
        article_report_t rep;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        // transfer happened at this edge
        if (predict_text_byte(b, last, rep))
            expected_reports = {expected_reports, (typed ? typed_rep : rep)};
        items_sent++;
    endtask

    // New pattern, length, mode and threshold; the registers are written only after the block drains.
    task automatic configure_phase(int phase);
        byte_t       pat [32];
        logic [63:0] word_val;
        int          len;
        int          active;
        int          r;
        logic [COUNT_W-1:0] min_val;

        r = $urandom_range(0, 99);
        if (phase == 0)     len = 32;
        else if (phase == 1) len = 0;
        else if (r < 55)    len = $urandom_range(1, 3);
        else if (r < 75)    len = $urandom_range(4, 10);
        else if (r < 85)    len = 32;
        else if (r < 93)    len = $urandom_range(33, 63);   // clamps to 32
        else                len = 0;
        active = (len > 32) ? 32 : len;

        // small alphabet in the live bytes so matches and overlaps actually happen
        for (int i = 0; i < 32; i++) begin
            r = $urandom_range(0, 99);
            if (i >= active)  pat[i] = byte_t'($urandom);
            else if (r < 45)  pat[i] = CHAR_LOWER_A;
            else if (r < 65)  pat[i] = CHAR_LOWER_B;
            else if (r < 75)  pat[i] = CHAR_UNDERSCORE;
            else if (r < 80)  pat[i] = CHAR_SPACE;
            else if (r < 85)  pat[i] = CHAR_HIGH;
            else              pat[i] = byte_t'($urandom_range(1, 255));
        end
        // a NUL inside the live bytes kills every match
        if (active > 0 && $urandom_range(0, 7) == 0) pat[$urandom_range(0, active - 1)] = CHAR_NUL;

        r = $urandom_range(0, 99);
        if (phase == 2)      min_val = '1;
        else if (phase == 3) min_val = '0;
        else if (phase == 4) min_val = 17'd65536;
        else if (r < 50)     min_val = 17'd1;
        else                 min_val = 17'($urandom_range(0, 4));

        drain_reports();
        for (int w = 0; w < 4; w++) begin
            for (int j = 0; j < 8; j++) word_val[j * 8 +: 8] = pat[w * 8 + j];
            write_reg(cfg_addr_t'(CFG_PATTERN_0 + w), word_val);
        end
        write_reg(CFG_PATTERN_LEN, with_noise(64'(len), 64'h3F));
        write_reg(CFG_WHOLE_WORDS,
                  with_noise(64'((phase < 4) ? phase % 2 : $urandom_range(0, 1)), 64'h1));
        write_reg(CFG_MIN_MATCHES, with_noise(64'(min_val), 64'h1FFFF));
    endtask

    // Random article: copies of the pattern mixed with word bytes, boundary bytes,
    // arbitrary bytes and the odd NUL. Mostly short, sometimes long enough to fill the window.
    task automatic send_article();
        byte_t text [$];
        int    n;
        int    r;
        int    len;
        len = eff_len();
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
        while (text.size() < n) begin
            r = $urandom_range(0, 99);
            if (r < 30 && len > 0) begin
                for (int k = 0; k < len; k++) text = {text, pat_word[k / 8][(k % 8) * 8 +: 8]};
            end else if (r < 50) begin
                text = {text, WORD_PICKS[$urandom_range(0, 7)]};
            end else if (r < 75) begin
                text = {text, EDGE_PICKS[$urandom_range(0, 7)]};
            end else if (r < 97) begin
                text = {text, byte_t'($urandom_range(1, 255))};
            end else begin
                text = {text, CHAR_NUL};
            end
        end
        foreach (text[i]) send_text(text[i], (i == text.size() - 1), 1'b0, '0);
    endtask

    // ---------------------------------------------------------------- m_ side
    // Receiver stalls in bursts of random length; none during the quiet tail.
    always @(posedge aclk) begin
        if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left != 0 && !quiet_tail) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Report checker: oldest expectation against each accepted report.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected report for article %0d at %0t",
                             m_article_index, $realtime);
            end else begin
                head_report = expected_reports.pop_front();
                if (seen_report !== head_report) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("report mismatch at %0t (expected/actual):", $realtime);
                        $display("  index %0d/%0d count %0d/%0d selected %0b/%0b total %0d/%0d",
                                 head_report.article_index, seen_report.article_index,
                                 head_report.match_count, seen_report.match_count,
                                 head_report.article_selected, seen_report.article_selected,
                                 head_report.selected_total, seen_report.selected_total);
                        $display("  words %0d/%0d new_max %0b/%0b max %0d/%0d max_index %0d/%0d",
                                 head_report.word_match_total, seen_report.word_match_total,
                                 head_report.new_maximum, seen_report.new_maximum,
                                 head_report.maximum_count, seen_report.maximum_count,
                                 head_report.maximum_article_index,
                                 seen_report.maximum_article_index);
                    end
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        int random_base;
        int phase_end;

        // model starts from the register defaults
        foreach (pat_word[i]) pat_word[i] = '0;
        pat_len_reg   = 6'd1;
        whole_mode    = 1'b0;
        min_count     = 17'd1;
        clear_article();
        articles_done = '0;
        selected_sum  = '0;
        match_sum     = '0;
        peak_count    = '0;
        peak_article  = '0;

        // Directed table. Defaults leave a NUL as the one pattern byte, so nothing
        // matches and the first two reports can be written down directly.
        add_row(text_row(CHAR_UPPER_A, 1'b0));
        add_row(typed_row(CHAR_UPPER_Z, 1'b1,
            '{24'd0, 17'd0, 1'b0, 24'd0, 40'd0, 1'b1, 17'd0, 24'd0}));
        // NUL as the very last byte still closes the article
        add_row(typed_row(CHAR_NUL, 1'b1,
            '{24'd1, 17'd0, 1'b0, 24'd0, 40'd0, 1'b1, 17'd0, 24'd1}));
        // "ab" as a whole word, threshold zero
        add_row(reg_row(CFG_PATTERN_0, 64'h6261));
        add_row(reg_row(CFG_PATTERN_LEN, 64'd2));
        add_row(reg_row(CFG_WHOLE_WORDS, 64'd1));
        add_row(reg_row(CFG_MIN_MATCHES, 64'd0));
        add_row(text_row(CHAR_LOWER_A, 1'b0));     // both edges are article edges
        add_row(text_row(CHAR_LOWER_B, 1'b1));
        add_row(text_row(CHAR_SPACE, 1'b0));       // underscore after: no match
        add_row(text_row(CHAR_LOWER_A, 1'b0));
        add_row(text_row(CHAR_LOWER_B, 1'b0));
        add_row(text_row(CHAR_UNDERSCORE, 1'b1));
        add_row(text_row(CHAR_9, 1'b0));           // digit before: no match
        add_row(text_row(CHAR_LOWER_A, 1'b0));
        add_row(text_row(CHAR_LOWER_B, 1'b1));
        add_row(text_row(CHAR_HIGH, 1'b0));        // high byte before, NUL after
        add_row(text_row(CHAR_LOWER_A, 1'b0));
        add_row(text_row(CHAR_LOWER_B, 1'b0));
        add_row(text_row(CHAR_NUL, 1'b0));
        add_row(text_row(CHAR_LOWER_A, 1'b0));     // ignored after the NUL
        add_row(text_row(CHAR_LOWER_B, 1'b1));
        // overlapping "aa", plain substring mode
        add_row(reg_row(CFG_PATTERN_0, 64'h6161));
        add_row(reg_row(CFG_WHOLE_WORDS, 64'd0));
        add_row(reg_row(CFG_MIN_MATCHES, 64'd3));
        add_row(text_row(CHAR_LOWER_A, 1'b0));
        add_row(text_row(CHAR_LOWER_A, 1'b0));
        add_row(text_row(CHAR_LOWER_A, 1'b0));
        add_row(text_row(CHAR_LOWER_A, 1'b1));
        // NUL inside the pattern never matches
        add_row(reg_row(CFG_PATTERN_0, 64'h0061));
        add_row(text_row(CHAR_LOWER_A, 1'b0));
        add_row(text_row(CHAR_NUL, 1'b1));
        // zero length never matches
        add_row(reg_row(CFG_PATTERN_LEN, 64'd0));
        add_row(text_row(CHAR_LOWER_A, 1'b1));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                drain_reports();
                write_reg(directed_rows[i].addr, directed_rows[i].data);
            end else begin
                send_text(directed_rows[i].text, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].report);
            end
        end

        // Random phases; each reconfigure waits for the block to drain first.
        random_base = items_sent;
        for (int phase = 0; items_sent - random_base < RANDOM_ITEMS; phase++) begin
            configure_phase(phase);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent - random_base < RANDOM_ITEMS) begin
                quiet_tail = (items_sent - random_base) > (RANDOM_ITEMS - QUIET_TAIL);
                send_article();
            end
        end

        drain_reports();
        repeat (8) @(posedge aclk);   // anything late shows up as an unexpected report
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
